// ===== sv/sfr_pkg.sv =====
// Shared constants, types and helpers for the sensor frame receiver.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int unsigned POS_W = 17;
  localparam int unsigned LEN_W = 16;

  // Frame layout positions
  localparam logic [POS_W-1:0] POS_LEN_HI   = 17'd8;
  localparam logic [POS_W-1:0] POS_LEN_LO   = 17'd9;
  localparam logic [POS_W-1:0] POS_HDR_SUM  = 17'd10;
  localparam logic [POS_W-1:0] POS_PAYLOAD  = 17'd11;
  localparam logic [POS_W-1:0] POS_VERIFY_L = 17'd14;

  typedef struct packed {
    logic [7:0]       byte_echo;
    logic             payload_valid;
    logic [LEN_W-1:0] payload_offset;
    logic             frame_ok;
    logic             frame_error;
  } result_t;

  // Fixed header byte at header position idx
  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hF1;
      3'd1:    b = 8'h1F;
      3'd2:    b = 8'hE2;
      3'd3:    b = 8'h2E;
      3'd4:    b = 8'hB6;
      3'd5:    b = 8'h6B;
      3'd6:    b = 8'hA8;
      3'd7:    b = 8'h8A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/sfr_core.sv =====
// Deframer state and per-byte decode: result of one word plus state update.
`timescale 1ns / 1ps

module sfr_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           rx_byte,
  input  logic [31:0]          verify_code,
  output sfr_pkg::result_t     result
);

  logic [sfr_pkg::POS_W-1:0] position, position_next;
  logic                      hunting, hunting_next;
  logic [7:0]                length_high, length_high_next;
  logic [sfr_pkg::LEN_W-1:0] frame_length, frame_length_next;
  logic [7:0]                header_sum, header_sum_next;
  logic [7:0]                payload_sum, payload_sum_next;

  logic [sfr_pkg::POS_W-1:0] pos;
  logic [sfr_pkg::POS_W-1:0] end_pos;
  logic [7:0]                verify_byte;
  logic                      ok, err, valid;
  logic [sfr_pkg::LEN_W-1:0] offset;
  logic [sfr_pkg::POS_W-1:0] pos_rel;

  assign pos     = hunting ? '0 : position;
  assign end_pos = sfr_pkg::POS_HDR_SUM + {1'b0, frame_length};
  assign pos_rel = pos - sfr_pkg::POS_PAYLOAD;

  // Bytes 11..14 map to verify code bytes, top byte first
  always_comb begin
    case (pos[1:0])
      2'b11:   verify_byte = verify_code[31:24];
      2'b00:   verify_byte = verify_code[23:16];
      2'b01:   verify_byte = verify_code[15:8];
      default: verify_byte = verify_code[7:0];
    endcase
  end

  always_comb begin
    ok                = 1'b0;
    err               = 1'b0;
    valid             = 1'b0;
    offset            = '0;
    length_high_next  = length_high;
    frame_length_next = frame_length;
    header_sum_next   = header_sum;
    payload_sum_next  = payload_sum;

    if (pos >= sfr_pkg::POS_PAYLOAD && pos == end_pos) begin
      // final checksum closes the frame
      if (rx_byte == 8'(8'd0 - payload_sum)) ok = 1'b1;
      else                                    err = 1'b1;
    end else if (pos < sfr_pkg::POS_LEN_HI) begin
      if (rx_byte != sfr_pkg::header_byte(pos[2:0])) err = 1'b1;
      header_sum_next = (pos == '0) ? rx_byte : 8'(header_sum + rx_byte);
    end else if (pos == sfr_pkg::POS_LEN_HI) begin
      length_high_next = rx_byte;
      header_sum_next  = 8'(header_sum + rx_byte);
    end else if (pos == sfr_pkg::POS_LEN_LO) begin
      frame_length_next = {length_high, rx_byte};
      header_sum_next   = 8'(header_sum + rx_byte);
      if ({length_high, rx_byte} == '0) err = 1'b1;
    end else if (pos == sfr_pkg::POS_HDR_SUM) begin
      if (rx_byte != 8'(8'd0 - header_sum)) err = 1'b1;
    end else begin
      valid  = 1'b1;
      offset = pos_rel[sfr_pkg::LEN_W-1:0];
      payload_sum_next = (pos == sfr_pkg::POS_PAYLOAD) ? rx_byte
                                                       : 8'(payload_sum + rx_byte);
      if (pos <= sfr_pkg::POS_VERIFY_L && rx_byte != verify_byte) err = 1'b1;
    end

    if (ok || err) begin
      position_next = '0;
      hunting_next  = 1'b1;
    end else begin
      position_next = pos + 1'b1;
      hunting_next  = 1'b0;
    end
  end

  assign result.byte_echo      = rx_byte;
  assign result.payload_valid  = valid;
  assign result.payload_offset = offset;
  assign result.frame_ok       = ok;
  assign result.frame_error    = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      hunting      <= 1'b1;
      length_high  <= '0;
      frame_length <= '0;
      header_sum   <= '0;
      payload_sum  <= '0;
    end else if (step) begin
      position     <= position_next;
      hunting      <= hunting_next;
      length_high  <= length_high_next;
      frame_length <= frame_length_next;
      header_sum   <= header_sum_next;
      payload_sum  <= payload_sum_next;
    end
  end

endmodule

// ===== sv/sensor_frame_receiver_top.sv =====
// Top level of the sensor frame receiver: stream ports, config register, output register.
`timescale 1ns / 1ps

// Sensor frame receiver.
// s_axis carries one received byte per word (tdata[7:0]). Each accepted word
// yields exactly one result word on m_axis: the byte echoed, its payload flag
// and offset, and frame_ok / frame_error flags.
// A frame is header F1 1F E2 2E B6 6B A8 8A, a big-endian length L, a header
// checksum, payload opening with up to four verify_code bytes, and a final
// checksum at position 10+L. After frame_ok or frame_error the next byte is
// taken as header byte 0.
// The result is captured in the output register at the accepting edge and
// offered on m_axis from the next cycle. Throughput: one word per cycle while
// m_axis is not stalled, set by the running sums and the position counter, all
// updated in the accepting cycle.
// The output register accepts a new word while its current word is taken in
// the same cycle; when m_axis stalls, s_tready drops and the held result
// stays stable until taken.
// Reset (rst, synchronous) clears the output valid, the frame state (back to
// hunting) and verify_code to zero. cfg_wen writes verify_code at once.

module sensor_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_wen,
  input  logic [31:0] cfg_wdata,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] byte_echo, [23:8] payload_offset
  output logic        m_axis_tlast,   // frame_ok
  output logic [1:0]  m_axis_tuser    // [0] payload_valid, [1] frame_error
);

  logic [31:0]      verify_code;
  logic             accept;
  sfr_pkg::result_t step_result;
  sfr_pkg::result_t out_word;
  logic             out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      verify_code <= '0;
    end else if (cfg_wen) begin
      verify_code <= cfg_wdata;
    end
  end

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  sfr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .rx_byte     (s_axis_tdata),
    .verify_code (verify_code),
    .result      (step_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_word.payload_offset, out_word.byte_echo};
  assign m_axis_tlast  = out_word.frame_ok;
  assign m_axis_tuser  = {out_word.frame_error, out_word.payload_valid};

endmodule

// ===== verif/sensor_frame_receiver_top_tb.sv =====
// Self-checking testbench for sensor_frame_receiver_top: frame stimulus, predictor, scoreboard.
`timescale 1ns / 1ps

module sensor_frame_receiver_top_tb;

  localparam int CYCLE_LIMIT = 400000;

  // Predicts the result word for every accepted byte and checks the words coming out.
  class frame_scoreboard;
    logic [7:0]  sync_seq [8];
    logic [31:0] verify_code;
    logic [16:0] next_pos;
    bit          hunting;
    logic [7:0]  len_hi;
    logic [15:0] frame_len;
    logic [7:0]  hdr_sum;
    logic [7:0]  pay_sum;
    sfr_pkg::result_t pending_q [$];
    int          err_count;
    int          print_cap;

    function new();
      sync_seq    = '{8'hF1, 8'h1F, 8'hE2, 8'h2E, 8'hB6, 8'h6B, 8'hA8, 8'h8A};
      verify_code = '0;
      next_pos    = '0;
      hunting     = 1'b1;
      len_hi      = '0;
      frame_len   = '0;
      hdr_sum     = '0;
      pay_sum     = '0;
      err_count   = 0;
      print_cap   = 100;
    endfunction

    function void set_verify(input logic [31:0] v);
      verify_code = v;
    endfunction

    // Runs one byte through the deframer state and queues the word it should produce.
    function void note_byte(input logic [7:0] b);
      logic [16:0] p;
      logic [16:0] off;
      logic [31:0] vword;
      logic [7:0]  neg;
      sfr_pkg::result_t r;
      p = hunting ? '0 : next_pos;
      r = '0;
      r.byte_echo = b;
      if (p >= sfr_pkg::POS_PAYLOAD && p == sfr_pkg::POS_HDR_SUM + {1'b0, frame_len}) begin
        // final checksum wins over verify checks on short frames
        neg = 8'd0 - pay_sum;
        r.frame_ok    = (b == neg);
        r.frame_error = (b != neg);
      end else if (p < sfr_pkg::POS_LEN_HI) begin
        if (b != sync_seq[p[2:0]])
          r.frame_error = 1'b1;
        hdr_sum = (p == '0) ? b : hdr_sum + b;
      end else if (p == sfr_pkg::POS_LEN_HI) begin
        len_hi  = b;
        hdr_sum = hdr_sum + b;
      end else if (p == sfr_pkg::POS_LEN_LO) begin
        frame_len = {len_hi, b};
        hdr_sum   = hdr_sum + b;
        if (frame_len == '0)
          r.frame_error = 1'b1;
      end else if (p == sfr_pkg::POS_HDR_SUM) begin
        neg = 8'd0 - hdr_sum;
        if (b != neg)
          r.frame_error = 1'b1;
      end else begin
        off = p - sfr_pkg::POS_PAYLOAD;
        r.payload_valid  = 1'b1;
        r.payload_offset = off[15:0];
        pay_sum = (p == sfr_pkg::POS_PAYLOAD) ? b : pay_sum + b;
        if (p <= sfr_pkg::POS_VERIFY_L) begin
          // verify bytes go out as payload even when they mismatch
          vword = verify_code >> (8 * (sfr_pkg::POS_VERIFY_L - p));
          if (b != vword[7:0])
            r.frame_error = 1'b1;
        end
      end
      if (r.frame_ok || r.frame_error) begin
        next_pos = '0;
        hunting  = 1'b1;
      end else begin
        next_pos = p + 1'b1;
        hunting  = 1'b0;
      end
      pending_q.push_back(r);
    endfunction

    task report_mismatch(input string msg);
      err_count++;
      if (err_count <= print_cap)
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_word(input sfr_pkg::result_t got);
      sfr_pkg::result_t want;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: echo=%h", got.byte_echo));
        return;
      end
      want = pending_q.pop_front();
      if (got.byte_echo !== want.byte_echo || got.payload_valid !== want.payload_valid ||
          got.payload_offset !== want.payload_offset || got.frame_ok !== want.frame_ok ||
          got.frame_error !== want.frame_error)
        report_mismatch($sformatf(
          "want echo=%h pv=%b off=%0d ok=%b err=%b, got echo=%h pv=%b off=%0d ok=%b err=%b",
          want.byte_echo, want.payload_valid, want.payload_offset, want.frame_ok,
          want.frame_error, got.byte_echo, got.payload_valid, got.payload_offset,
          got.frame_ok, got.frame_error));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] byte_echo, [23:8] payload_offset
  logic        m_axis_tlast;        // frame_ok
  logic [1:0]  m_axis_tuser;        // [0] payload_valid, [1] frame_error

  frame_scoreboard  sb;
  sfr_pkg::result_t got_word;
  logic [31:0]      cur_verify = '0;
  bit               s_calm = 1'b0;
  bit               m_calm = 1'b0;
  int               stall_left = 0;
  int               bytes_sent = 0;
  int               cycle_count = 0;

  sensor_frame_receiver_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // Idle lengths: mostly short, now and then long.
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8)
      return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic int sender_gap();
    if (s_calm || $urandom_range(0, 9) < 6)
      return 0;
    return idle_len();
  endfunction

  // Result side: random back-pressure, driven on the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!m_calm && $urandom_range(0, 99) < 30)
        stall_left <= idle_len();
    end
  end

  // Sample result words on the rising edge.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_word.byte_echo      = m_axis_tdata[7:0];
      got_word.payload_valid  = m_axis_tuser[0];
      got_word.payload_offset = m_axis_tdata[23:8];
      got_word.frame_ok       = m_axis_tlast;
      got_word.frame_error    = m_axis_tuser[1];
      sb.check_word(got_word);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one byte and holds it until taken; entered and left on a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Drains the pipe, then writes verify_code with no word in flight.
  task automatic write_verify(input logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen    <= 1'b0;
    cur_verify = v;
    sb.set_verify(v);
  endtask

  // Builds a frame of length len. trunc: stop after the verify bytes and break one of
  // them (lets huge lengths through cheaply). corrupt: flip one random byte.
  task automatic play_frame(input logic [15:0] len, input bit trunc, input bit corrupt);
    logic [7:0] fq [$];
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] flip;
    int         n_body;
    int         idx;
    sum = '0;
    for (int i = 0; i < sfr_pkg::POS_LEN_HI; i++) begin
      fq.push_back(sb.sync_seq[i]);
      sum = sum + sb.sync_seq[i];
    end
    fq.push_back(len[15:8]);
    fq.push_back(len[7:0]);
    sum = sum + len[15:8];
    sum = sum + len[7:0];
    if (len != '0) begin
      fq.push_back(8'd0 - sum);
      sum = '0;
      n_body = trunc ? 4 : int'(len) - 1;
      for (int k = 0; k < n_body; k++) begin
        if (k < 4)
          b = 8'(cur_verify >> (8 * (3 - k)));
        else
          b = 8'($urandom_range(0, 255));
        fq.push_back(b);
        sum = sum + b;
      end
      if (!trunc)
        fq.push_back(8'd0 - sum);
    end
    flip = 8'($urandom_range(1, 255));
    if (trunc) begin
      idx = int'($urandom_range(sfr_pkg::POS_VERIFY_L, sfr_pkg::POS_PAYLOAD));
      fq[idx] = fq[idx] ^ flip;
    end else if (corrupt) begin
      idx = int'($urandom_range(0, fq.size() - 1));
      fq[idx] = fq[idx] ^ flip;
    end
    foreach (fq[i])
      send_byte(fq[i]);
  endtask

  // Mostly well-formed frames with random payload; some noise and broken frames.
  task automatic run_random(input int n_bytes);
    int first;
    int pick;
    int n_noise;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      s_calm = ($urandom_range(0, 3) == 0);
      m_calm = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 99);
      if (pick < 8) begin
        n_noise = $urandom_range(1, 3);
        repeat (n_noise)
          send_byte(($urandom_range(0, 1) == 0) ? 8'hF1 : 8'($urandom_range(0, 255)));
      end else if (pick < 13) begin
        play_frame(16'd0, 1'b0, 1'b0);
      end else if (pick < 18) begin
        play_frame(16'($urandom_range(5, 65535)), 1'b1, 1'b0);
      end else if (pick < 21) begin
        play_frame(16'($urandom_range(256, 400)), 1'b0, 1'b0);
      end else if ($urandom_range(0, 3) == 0) begin
        // short frames: final checksum lands among the verify bytes
        play_frame(16'($urandom_range(1, 4)), 1'b0, ($urandom_range(0, 99) < 25));
      end else begin
        play_frame(16'($urandom_range(5, 24)), 1'b0, ($urandom_range(0, 99) < 25));
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: noise at the extremes while hunting, a one-byte frame, a zero length.
    write_verify(32'h0000_0000);
    send_byte(8'hFF);
    send_byte(8'h00);
    play_frame(16'd1, 1'b0, 1'b0);
    play_frame(16'd0, 1'b0, 1'b0);

    write_verify(32'hFFFF_FFFF);
    run_random(150);
    write_verify($urandom);
    run_random(150);
    write_verify(32'h8000_0001);
    run_random(150);
    write_verify($urandom);
    run_random(150);

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.report_mismatch($sformatf("%0d result words never arrived", sb.pending_q.size()));
    if (sb.err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
